// File: hw/rtl/tcet_pkg.sv
`default_nettype none

package tcet_pkg;

  // Sine ROM and phase accumulator geometry
  localparam int SineEntries = 256;
  localparam int PhaseBits   = 16;
  localparam int SineIdxBits = $clog2(SineEntries);

  // Operation codes of an input request
  localparam logic OpAdvance = 1'b0;
  localparam logic OpRestart = 1'b1;

  // Configuration register indexes
  localparam int CfgIdxBits = 4;
  localparam logic [CfgIdxBits-1:0] CfgArpOffsets  = 4'd0;
  localparam logic [CfgIdxBits-1:0] CfgArpRate     = 4'd1;
  localparam logic [CfgIdxBits-1:0] CfgVibrato     = 4'd2;
  localparam logic [CfgIdxBits-1:0] CfgTremolo     = 4'd3;
  localparam logic [CfgIdxBits-1:0] CfgRetrigRate  = 4'd4;
  localparam logic [CfgIdxBits-1:0] CfgCutAtTick   = 4'd5;
  localparam logic [CfgIdxBits-1:0] CfgDelayAtTick = 4'd6;
  localparam logic [CfgIdxBits-1:0] CfgEnvelope    = 4'd7;
  localparam int CfgDataBits = 32;

  // Reciprocal of 100 in Q32, rounded down; quotient is corrected afterwards
  localparam logic [25:0] DivRecip100 = 26'((64'd1 << 32) / 100);

  // One classified request as it sits in the queue
  typedef struct packed {
    logic        restart;
    logic [15:0] chan_freq;
  } tcet_item_t;

  // Queue head toward the back end
  typedef struct packed {
    logic       valid;
    tcet_item_t item;
  } tcet_head_t;

  typedef logic signed [15:0] sine_rom_t [SineEntries];
  typedef logic [PhaseBits-1:0] phase_tab_t [256];

  // Q1.15 sine entry from a Q30 Taylor series on a quarter wave
  function automatic logic signed [15:0] sine_entry(input int unsigned idx);
    longint unsigned q;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    logic            neg;
    neg = 1'b0;
    q = (64'(idx) << 32) / SineEntries;
    if (q >= 64'h8000_0000) begin
      neg = 1'b1;
      q = q - 64'h8000_0000;
    end
    if (q > 64'h4000_0000) q = 64'h8000_0000 - q;
    x = (q * 64'd3373259426) >> 31;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (64'(sum) * 64'd32767 + 64'h2000_0000) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return neg ? -16'(v) : 16'(v);
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t t;
    for (int i = 0; i < SineEntries; i++) t[i] = sine_entry(i);
    return t;
  endfunction

  // Phase step per tick for a speed in hundredths of a cycle
  function automatic phase_tab_t build_phase_inc();
    phase_tab_t      t;
    longint unsigned v;
    for (int s = 0; s < 256; s++) begin
      v = ((64'(s) << PhaseBits) + 64'd50) / 100;
      t[s] = PhaseBits'(v);
    end
    return t;
  endfunction

  localparam sine_rom_t  SineRom  = build_sine();
  localparam phase_tab_t PhaseInc = build_phase_inc();

endpackage

`default_nettype wire

// File: hw/rtl/tcet_front.sv
`default_nettype none

module tcet_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire                 in_operation,
  input  wire  [15:0]         in_chan_freq,
  output tcet_pkg::tcet_head_t head,
  input  wire                 pop
);

  tcet_pkg::tcet_item_t slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop_ok;
  tcet_pkg::tcet_item_t item_in;

  // Classify the incoming request
  always_comb begin
    item_in.restart   = (in_operation == tcet_pkg::OpRestart);
    item_in.chan_freq = in_chan_freq;
  end

  assign in_stall  = (count_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign pop_ok    = pop && (count_r != 2'd0);
  assign head.valid = (count_r != 2'd0);
  assign head.item  = slot_r[rd_ptr_r];

  // Hold requests until the back end takes them
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop_ok) rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop_ok) count_r <= count_r + 2'd1;
      else if (pop_ok && !push) count_r <= count_r - 2'd1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tcet_back.sv
`default_nettype none

module tcet_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire  [3:0]          cfg_index,
  input  wire  [31:0]         cfg_wdata,
  input  tcet_pkg::tcet_head_t head,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic signed [19:0]  out_freq_offset,
  output logic [15:0]         out_volume_gain,
  output logic signed [7:0]   out_arp_semitones,
  output logic                out_trigger_note,
  output logic                out_cut_note
);

  localparam int PB = tcet_pkg::PhaseBits;
  localparam int IB = tcet_pkg::SineIdxBits;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UPDATE = 8'b0000_0010,
    S_SINE_V = 8'b0000_0100,
    S_MUL_V  = 8'b0000_1000,
    S_ROUND  = 8'b0001_0000,
    S_DIV_M  = 8'b0010_0000,
    S_DIV_C  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [15:0]       arp_offsets_r;
  logic [7:0]        arp_rate_r;
  logic [15:0]       vib_set_r;
  logic [15:0]       trem_set_r;
  logic [7:0]        retrig_rate_r;
  logic signed [8:0] cut_at_r;
  logic signed [8:0] delay_at_r;
  logic [31:0]       env_set_r;

  // Channel state
  logic [15:0]        tick_r;
  logic [1:0]         arp_step_r;
  logic [7:0]         arp_cnt_r;
  logic [PB-1:0]      vib_phase_r;
  logic [PB-1:0]      trem_phase_r;
  logic [7:0]         retrig_cnt_r;
  logic signed [15:0] env_r;

  // Per-request datapath
  logic               restart_r;
  logic [15:0]        base_r;
  logic               fired_r;
  logic signed [15:0] sine_r;
  logic [23:0]        bd_r;
  logic [38:0]        mag_r;
  logic               vneg_r;
  logic [24:0]        t_r;
  logic [23:0]        gprod_r;
  logic [18:0]        q_r;
  logic [17:0]        vr_r;
  logic [15:0]        gain_r;

  logic               out_valid_r;
  logic signed [19:0] out_offset_r;
  logic [15:0]        out_gain_r;
  logic signed [7:0]  out_semis_r;
  logic               out_trig_r;
  logic               out_cut_r;

  // Next values of the tick update
  logic [15:0]        tick_nxt;
  logic [1:0]         arp_step_nxt;
  logic [7:0]         arp_cnt_nxt;
  logic [PB-1:0]      vib_phase_nxt;
  logic [PB-1:0]      trem_phase_nxt;
  logic [7:0]         retrig_cnt_nxt;
  logic signed [15:0] env_nxt;
  logic               fired_nxt;

  logic        vib_on;
  logic        trem_on;
  logic        arp_on;
  logic signed [17:0] env_ext;
  logic signed [17:0] env_dec;
  logic signed [17:0] env_inc;

  logic [24:0] mul_a;
  logic [25:0] mul_b;
  logic [50:0] mul_p;
  logic [14:0] sine_abs;
  logic [24:0] q_x100;
  logic [24:0] rem_v;
  logic [24:0] gain_v;
  logic signed [20:0] off_sum;
  logic signed [19:0] off_sat;
  logic signed [7:0]  semis_v;
  logic        trig_v;
  logic        cut_v;
  logic        out_free;

  assign vib_on  = (vib_set_r[15:8] != 8'd0);
  assign trem_on = (trem_set_r[15:8] != 8'd0);
  assign arp_on  = (arp_offsets_r != 16'd0);

  // Advance or restart the channel state for one tick
  always_comb begin
    tick_nxt       = tick_r;
    arp_step_nxt   = arp_step_r;
    arp_cnt_nxt    = arp_cnt_r;
    vib_phase_nxt  = vib_phase_r;
    trem_phase_nxt = trem_phase_r;
    retrig_cnt_nxt = retrig_cnt_r;
    env_nxt        = env_r;
    fired_nxt      = 1'b0;
    env_ext = {{2{env_r[15]}}, env_r};
    env_dec = env_ext - $signed({2'b00, env_set_r[15:0]});
    env_inc = env_ext + $signed({2'b00, env_set_r[15:0]});
    if (restart_r) begin
      tick_nxt       = 16'd0;
      retrig_cnt_nxt = 8'd0;
      env_nxt        = $signed(env_set_r[31:16]);
    end else begin
      if (tick_r != 16'hFFFF) tick_nxt = tick_r + 16'd1;
      if (arp_on) begin
        arp_cnt_nxt = arp_cnt_r + 8'd1;
        if (arp_cnt_nxt >= arp_rate_r) begin
          arp_cnt_nxt  = 8'd0;
          arp_step_nxt = (arp_step_r == 2'd2) ? 2'd0 : arp_step_r + 2'd1;
        end
      end
      if (vib_on) vib_phase_nxt = vib_phase_r + tcet_pkg::PhaseInc[vib_set_r[7:0]];
      if (trem_on) trem_phase_nxt = trem_phase_r + tcet_pkg::PhaseInc[trem_set_r[7:0]];
      if (retrig_rate_r != 8'd0) begin
        retrig_cnt_nxt = retrig_cnt_r + 8'd1;
        if (retrig_cnt_nxt >= retrig_rate_r) begin
          fired_nxt      = 1'b1;
          retrig_cnt_nxt = 8'd0;
        end
      end
      if (env_r > 16'sd0) begin
        env_nxt = env_dec[17] ? 16'sd0 : env_dec[15:0];
      end else if (env_r < 16'sd0) begin
        env_nxt = (env_inc > 18'sd0) ? 16'sd0 : env_inc[15:0];
      end
    end
  end

  // Route operands to the shared multiplier
  assign sine_abs = sine_r[15] ? 15'(-sine_r) : sine_r[14:0];

  always_comb begin
    mul_a = 25'd0;
    mul_b = 26'd0;
    case (state_r)
      S_SINE_V: begin
        mul_a = {9'd0, base_r};
        mul_b = {18'd0, vib_set_r[15:8]};
      end
      S_MUL_V: begin
        mul_a = {1'b0, bd_r};
        mul_b = {11'd0, sine_abs};
      end
      S_ROUND: begin
        mul_a = {9'd0, ~sine_r[15], sine_r[14:0]};
        mul_b = {18'd0, trem_set_r[15:8]};
      end
      S_DIV_M: begin
        mul_a = t_r;
        mul_b = tcet_pkg::DivRecip100;
      end
      default: begin
        mul_a = 25'd0;
        mul_b = 26'd0;
      end
    endcase
  end

  assign mul_p = {26'd0, mul_a} * {25'd0, mul_b};

  // Quotient correction and tremolo gain
  assign q_x100 = {q_r, 6'd0} + {1'b0, q_r, 5'd0} + {4'd0, q_r, 2'd0};
  assign rem_v  = t_r - q_x100;
  assign gain_v = 25'h100_0080 - {1'b0, gprod_r};

  // Assemble the result fields
  always_comb begin
    off_sum = {{5{env_r[15]}}, env_r};
    if (vib_on) begin
      if (vneg_r) off_sum = off_sum - $signed({3'd0, vr_r});
      else off_sum = off_sum + $signed({3'd0, vr_r});
    end
    if (off_sum[20] != off_sum[19]) off_sat = off_sum[20] ? 20'sh80000 : 20'sh7FFFF;
    else off_sat = off_sum[19:0];
    semis_v = 8'sd0;
    if (arp_on) begin
      if (arp_step_r == 2'd1) semis_v = arp_offsets_r[7:0];
      else if (arp_step_r == 2'd2) semis_v = arp_offsets_r[15:8];
    end
    trig_v = fired_r || (!delay_at_r[8] && tick_r == {8'd0, delay_at_r[7:0]});
    cut_v  = !cut_at_r[8] && (tick_r >= {8'd0, cut_at_r[7:0]});
  end

  assign out_free = !out_valid_r || !out_stall;

  // Sequence one request through the shared multiplier
  always_comb begin
    state_nxt = state_r;
    pop = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: state_nxt = S_SINE_V;
      S_SINE_V: state_nxt = S_MUL_V;
      S_MUL_V:  state_nxt = S_ROUND;
      S_ROUND:  state_nxt = S_DIV_M;
      S_DIV_M:  state_nxt = S_DIV_C;
      S_DIV_C:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        restart_r <= head.item.restart;
        base_r    <= head.item.chan_freq;
      end
      S_SINE_V: begin
        sine_r <= tcet_pkg::SineRom[vib_phase_r[PB-1 -: IB]];
        bd_r   <= mul_p[23:0];
      end
      S_MUL_V: begin
        mag_r  <= mul_p[38:0];
        vneg_r <= sine_r[15];
        sine_r <= tcet_pkg::SineRom[trem_phase_r[PB-1 -: IB]];
      end
      S_ROUND: begin
        t_r     <= 25'(({1'b0, mag_r} + 40'd1638400) >> 15);
        gprod_r <= mul_p[23:0];
      end
      S_DIV_M: q_r <= mul_p[50:32];
      S_DIV_C: begin
        vr_r   <= 18'(q_r + ((rem_v >= 25'd100) ? 19'd1 : 19'd0));
        gain_r <= trem_on ? ((gain_v[24:8] > 17'd65535) ? 16'hFFFF : gain_v[23:8])
                          : 16'hFFFF;
      end
      default: begin
      end
    endcase
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_offset_r <= off_sat;
      out_gain_r   <= gain_r;
      out_semis_r  <= semis_v;
      out_trig_r   <= trig_v;
      out_cut_r    <= cut_v;
    end
  end

  // Control, configuration and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      fired_r       <= 1'b0;
      arp_offsets_r <= 16'd0;
      arp_rate_r    <= 8'd1;
      vib_set_r     <= 16'd0;
      trem_set_r    <= 16'd0;
      retrig_rate_r <= 8'd0;
      cut_at_r      <= -9'sd1;
      delay_at_r    <= -9'sd1;
      env_set_r     <= 32'd0;
      tick_r        <= 16'd0;
      arp_step_r    <= 2'd0;
      arp_cnt_r     <= 8'd0;
      vib_phase_r   <= '0;
      trem_phase_r  <= '0;
      retrig_cnt_r  <= 8'd0;
      env_r         <= 16'sd0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_DONE) && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      if (state_r == S_UPDATE) begin
        tick_r       <= tick_nxt;
        arp_step_r   <= arp_step_nxt;
        arp_cnt_r    <= arp_cnt_nxt;
        vib_phase_r  <= vib_phase_nxt;
        trem_phase_r <= trem_phase_nxt;
        retrig_cnt_r <= retrig_cnt_nxt;
        env_r        <= env_nxt;
        fired_r      <= fired_nxt;
      end

      // Apply register writes and the state they reset
      if (cfg_we) begin
        case (cfg_index)
          tcet_pkg::CfgArpOffsets: begin
            arp_offsets_r <= cfg_wdata[15:0];
            arp_step_r    <= 2'd0;
            arp_cnt_r     <= 8'd0;
          end
          tcet_pkg::CfgArpRate: begin
            arp_rate_r <= (cfg_wdata[7:0] == 8'd0) ? 8'd1 : cfg_wdata[7:0];
            arp_step_r <= 2'd0;
            arp_cnt_r  <= 8'd0;
          end
          tcet_pkg::CfgVibrato: begin
            vib_set_r <= cfg_wdata[15:0];
            if (cfg_wdata[15:8] == 8'd0) vib_phase_r <= '0;
          end
          tcet_pkg::CfgTremolo: trem_set_r <= cfg_wdata[15:0];
          tcet_pkg::CfgRetrigRate: begin
            retrig_rate_r <= cfg_wdata[7:0];
            retrig_cnt_r  <= 8'd0;
          end
          tcet_pkg::CfgCutAtTick:   cut_at_r   <= cfg_wdata[8:0];
          tcet_pkg::CfgDelayAtTick: delay_at_r <= cfg_wdata[8:0];
          tcet_pkg::CfgEnvelope: begin
            env_set_r <= cfg_wdata;
            env_r     <= cfg_wdata[31:16];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_freq_offset   = out_offset_r;
  assign out_volume_gain   = out_gain_r;
  assign out_arp_semitones = out_semis_r;
  assign out_trigger_note  = out_trig_r;
  assign out_cut_note      = out_cut_r;

endmodule

`default_nettype wire

// File: hw/rtl/tracker_channel_effects_tick.sv
// Tracker channel effect engine, one instance per channel.
// Input channel: in_valid/in_stall with in_operation (advance one effect
// tick, or restart note counters and envelope) and in_chan_freq (Q12.4 Hz).
// Result channel: out_valid/out_stall with one result per request: the
// vibrato plus envelope offset, tremolo gain, arpeggio semitones and the
// trigger and cut flags.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 to 7);
// unknown indexes are ignored. Write only while no request is in flight.
// The back-end sequencer runs the vibrato and tremolo products and the
// divide by 100 through one multiplier, so it takes a new request only
// after the last result has left its final step.
// A two-entry queue in front takes up to two more requests while the
// back end works; in_stall rises when that queue is full.
// A stalled result holds on the outputs; the back end then waits in its
// last step and the queue fills behind it.
// Reset (rst_n low, synchronous) clears the queue, the result valid flag and
// all effect state, and loads the register defaults.
`default_nettype none

module tracker_channel_effects_tick (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [3:0]         cfg_index,
  input  wire  [31:0]        cfg_wdata,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                in_operation,
  input  wire  [15:0]        in_chan_freq,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [19:0] out_freq_offset,
  output logic [15:0]        out_volume_gain,
  output logic signed [7:0]  out_arp_semitones,
  output logic               out_trigger_note,
  output logic               out_cut_note
);

  tcet_pkg::tcet_head_t head;
  logic                 pop;

  tcet_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_chan_freq (in_chan_freq),
    .head         (head),
    .pop          (pop)
  );

  tcet_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_freq_offset   (out_freq_offset),
    .out_volume_gain   (out_volume_gain),
    .out_arp_semitones (out_arp_semitones),
    .out_trigger_note  (out_trigger_note),
    .out_cut_note      (out_cut_note)
  );

endmodule

`default_nettype wire
